// File: design/plist_pkg.sv
// Shared constants and types for the positional character list.
package plist_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // rank compares run one bit above the 8-bit position field
    localparam int RANK_W   = 9;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_PRINT  = 2'd1,
        FN_READ   = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_CHAR    = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_RUN   = 2'd1,
        S_DRAIN = 2'd2,
        S_PUT   = 2'd3
    } t_state;

endpackage

// File: design/positional_char_list.sv
// Positional character list: byte store with rank-based insert, read, remove, print.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+---------------------------
//   command  | i_func, i_position, i_char_in                | taken when start && !busy
//   result   | o_status, o_char_out, o_last                 | one-cycle strobe o_valid
//
// One store walk reads one entry per cycle through a store with one read and
// one write port and registered read data; the walk ends in a drain state.
// Insert: count-rank+1 moves, then the new byte is written (appending writes it at once).
// Remove: count-rank moves, then the count drops (removing the tail only drops the count).
// Print reads every entry; read reads one entry; error and empty results need no walk.
// Reset clears the count, sequencer and valid flags only; the receiver cannot stall.
module positional_char_list import plist_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_position,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_char_out,
    output logic       o_last
);

    logic [7:0]        r_mem [CAPACITY];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_func             r_op, n_op;
    logic [ADDR_W-1:0] r_pos0, n_pos0;
    logic [7:0]        r_char, n_char;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_end, n_end;

    logic              r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic              r_rd_last, n_rd_last;
    logic [7:0]        r_rd_data;
    logic              rd_en;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [7:0]        r_char_out, n_char_out;
    logic              r_last, n_last;

    logic              accept;
    t_func             func;
    logic [7:0]        pos_m1;
    logic [ADDR_W-1:0] p0;
    logic [ADDR_W-1:0] cnt_m1;
    logic [RANK_W-1:0] rank, cnt_ext;
    logic              ins_bad, rr_bad, full, empty, ins_tail, rem_tail;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);
    assign func   = t_func'(i_func);

    assign pos_m1  = i_position - 8'd1;
    assign p0      = pos_m1[ADDR_W-1:0];
    assign cnt_m1  = ADDR_W'(r_count - CNT_W'(1));
    assign rank    = RANK_W'(i_position);
    assign cnt_ext = RANK_W'(r_count);

    assign ins_bad  = (i_position == 8'd0) || (rank > cnt_ext + RANK_W'(1));
    assign rr_bad   = (i_position == 8'd0) || (rank > cnt_ext);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign ins_tail = (rank == cnt_ext + RANK_W'(1));
    assign rem_tail = (rank == cnt_ext);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (func)
                        FN_INSERT: begin
                            if (!ins_bad && !full) begin
                                n_state = ins_tail ? S_PUT : S_RUN;
                            end
                        end
                        FN_PRINT: begin
                            if (!empty) begin
                                n_state = S_RUN;
                            end
                        end
                        FN_READ: begin
                            if (!rr_bad) begin
                                n_state = S_RUN;
                            end
                        end
                        FN_REMOVE: begin
                            if (!rr_bad && !rem_tail) begin
                                n_state = S_RUN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RUN: begin
                if (r_ptr == r_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = (r_op == FN_INSERT) ? S_PUT : S_IDLE;
            S_PUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_count    = r_count;
        n_op       = r_op;
        n_pos0     = r_pos0;
        n_char     = r_char;
        n_ptr      = r_ptr;
        n_end      = r_end;
        n_rd_vld   = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_rd_last  = r_rd_last;
        rd_en      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_rd_addr;
        mem_wdata  = r_rd_data;
        n_valid    = 1'b0;
        n_status   = STAT_CHAR;
        n_char_out = 8'd0;
        n_last     = 1'b0;

        // retire the word read last cycle
        if (r_rd_vld) begin
            case (r_op)
                FN_INSERT: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_addr + ADDR_W'(1);
                end
                FN_REMOVE: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_addr - ADDR_W'(1);
                end
                default: begin
                    n_valid    = 1'b1;
                    n_status   = STAT_CHAR;
                    n_char_out = r_rd_data;
                    n_last     = r_rd_last;
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = func;
                    n_pos0 = p0;
                    n_char = i_char_in;
                    case (func)
                        FN_INSERT: begin
                            if (ins_bad || full) begin
                                n_valid  = 1'b1;
                                n_status = ins_bad ? STAT_INVALID : STAT_FULL;
                                n_last   = 1'b1;
                            end else begin
                                n_ptr = cnt_m1;
                                n_end = p0;
                            end
                        end
                        FN_PRINT: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = STAT_EMPTY;
                                n_last   = 1'b1;
                            end else begin
                                n_ptr = '0;
                                n_end = cnt_m1;
                            end
                        end
                        FN_READ: begin
                            if (rr_bad) begin
                                n_valid  = 1'b1;
                                n_status = STAT_INVALID;
                                n_last   = 1'b1;
                            end else begin
                                n_ptr = p0;
                                n_end = p0;
                            end
                        end
                        FN_REMOVE: begin
                            if (rr_bad) begin
                                n_valid  = 1'b1;
                                n_status = STAT_INVALID;
                                n_last   = 1'b1;
                            end else if (rem_tail) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_ptr = p0 + ADDR_W'(1);
                                n_end = cnt_m1;
                            end
                        end
                        default: n_op = func;
                    endcase
                end
            end
            S_RUN: begin
                rd_en     = 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_addr = r_ptr;
                n_rd_last = (r_ptr == r_end);
                if (r_ptr != r_end) begin
                    // insert walks down from the tail, the others walk up
                    n_ptr = (r_op == FN_INSERT) ? r_ptr - ADDR_W'(1) : r_ptr + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_op == FN_REMOVE) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos0;
                mem_wdata = r_char;
                n_count   = r_count + CNT_W'(1);
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pos0     <= n_pos0;
        r_char     <= n_char;
        r_ptr      <= n_ptr;
        r_end      <= n_end;
        r_rd_addr  <= n_rd_addr;
        r_rd_last  <= n_rd_last;
        r_status   <= n_status;
        r_char_out <= n_char_out;
        r_last     <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_char_out = r_char_out;
    assign o_last     = r_last;

endmodule
